/* rtl/mexp_pkg.sv */
// shared types and constants for the modular exponentiation block
// no dependencies; used by every other file in rtl except mexp_mulmod

package mexp_pkg;

    // fixed width of the data words on the ports
    localparam int DATA_WIDTH = 32;

    // default operand width, legal range 8 to 32
    localparam int OPERAND_WIDTH_DEF = 32;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EXPONENT = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS  = 1'b1;

    // what the shared modular multiplier is asked to do
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_MULT,
        OP_SQUARE
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_START,
        ST_RED_WAIT,
        ST_CHECK,
        ST_MUL_WAIT,
        ST_SQR_START,
        ST_SQR_WAIT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic start;
        op_t  op;
        logic emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_done;
        logic e_zero;
        logic e_bit0;
    } sts_t;

endpackage

/* rtl/mexp_base_if.sv */
// valid/ready channel that carries one base word into the block
// depends on mexp_pkg for the word width

interface mexp_base_if;
    logic                            valid;
    logic                            ready;
    logic [mexp_pkg::DATA_WIDTH-1:0] base;

    modport source (output valid, output base, input ready);
    modport sink   (input valid, input base, output ready);
endinterface

/* rtl/mexp_power_if.sv */
// valid/ready channel that carries one power word out of the block
// depends on mexp_pkg for the word width

interface mexp_power_if;
    logic                            valid;
    logic                            ready;
    logic [mexp_pkg::DATA_WIDTH-1:0] power;

    modport source (output valid, output power, input ready);
    modport sink   (input valid, input power, output ready);
endinterface

/* rtl/mexp_mulmod.sv */
// iterative modular multiplier: x * y mod m, one bit of y per cycle
// interleaved shift-subtract, needs x <= m; no package dependencies

module mexp_mulmod #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic [W-1:0] result,
    output logic         done
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  x_reg;
    logic [W-1:0]  y_reg;
    logic [W-1:0]  m_reg;
    logic [W-1:0]  r_reg;
    logic [W-1:0]  r_next;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W+1:0] t;
    logic [W+1:0] m1;
    logic [W+1:0] m2;
    logic [W+1:0] t_red;

    // t stays below 3m, so at most one of m or 2m comes off
    always_comb
    begin
        t  = {1'b0, r_reg, 1'b0} + {2'b00, x_reg & {W{y_reg[W-1]}}};
        m1 = {2'b00, m_reg};
        m2 = {1'b0, m_reg, 1'b0};
        if (t >= m2)
        begin
            t_red = t - m2;
        end
        else if (t >= m1)
        begin
            t_red = t - m1;
        end
        else
        begin
            t_red = t;
        end
        r_next = t_red[W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
            r_reg <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
            y_reg <= {y_reg[W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign result = r_reg;
    assign done   = done_reg;

endmodule

/* rtl/mexp_datapath.sv */
// datapath: operand registers, exponent shifter and the shared mulmod unit
// depends on mexp_pkg and mexp_mulmod

module mexp_datapath #(
    parameter int W = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mexp_pkg::cmd_t                  cmd,
    output mexp_pkg::sts_t                  sts,
    input  logic [mexp_pkg::DATA_WIDTH-1:0] base,
    input  logic [mexp_pkg::DATA_WIDTH-1:0] exponent,
    input  logic [mexp_pkg::DATA_WIDTH-1:0] modulus,
    output logic [W-1:0]                    power
);

    logic [W-1:0]  b_reg;
    logic [W-1:0]  e_reg;
    logic [W-1:0]  m_reg;
    logic [W-1:0]  acc_reg;
    logic [W-1:0]  power_reg;
    mexp_pkg::op_t op_reg;

    logic [W-1:0] mul_x;
    logic [W-1:0] mul_y;
    logic [W-1:0] mul_result;
    logic         mul_done;

    always_comb
    begin
        case (cmd.op)
            mexp_pkg::OP_REDUCE:
            begin
                mul_x = W'(1);
                mul_y = b_reg;
            end
            mexp_pkg::OP_MULT:
            begin
                mul_x = b_reg;
                mul_y = acc_reg;
            end
            mexp_pkg::OP_SQUARE:
            begin
                mul_x = b_reg;
                mul_y = b_reg;
            end
            default:
            begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    mexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .x      (mul_x),
        .y      (mul_y),
        .m      (m_reg),
        .result (mul_result),
        .done   (mul_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            b_reg   <= base[W-1:0];
            e_reg   <= exponent[W-1:0];
            // a zero modulus behaves as one
            m_reg   <= (modulus[W-1:0] == '0) ? W'(1) : modulus[W-1:0];
            acc_reg <= W'(1);
        end
        else if (mul_done)
        begin
            case (op_reg)
                mexp_pkg::OP_REDUCE:
                begin
                    b_reg <= mul_result;
                end
                mexp_pkg::OP_MULT:
                begin
                    acc_reg <= mul_result;
                end
                mexp_pkg::OP_SQUARE:
                begin
                    b_reg <= mul_result;
                    e_reg <= {1'b0, e_reg[W-1:1]};
                end
                default:
                begin
                    b_reg <= b_reg;
                end
            endcase
        end
        if (cmd.start)
        begin
            op_reg <= cmd.op;
        end
        if (cmd.emit)
        begin
            power_reg <= acc_reg;
        end
    end

    assign sts.mul_done = mul_done;
    assign sts.e_zero   = (e_reg == '0);
    assign sts.e_bit0   = e_reg[0];
    assign power        = power_reg;

endmodule

/* rtl/mexp_ctrl.sv */
// controller: sequences the square-and-multiply steps and the handshakes
// depends on mexp_pkg

module mexp_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mexp_pkg::cmd_t cmd,
    input  mexp_pkg::sts_t sts
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        req_ready      = 1'b0;
        cmd.load       = 1'b0;
        cmd.start      = 1'b0;
        cmd.op         = mexp_pkg::OP_REDUCE;
        cmd.emit       = 1'b0;
        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = mexp_pkg::ST_RED_START;
                end
            end
            mexp_pkg::ST_RED_START:
            begin
                cmd.start  = 1'b1;
                cmd.op     = mexp_pkg::OP_REDUCE;
                state_next = mexp_pkg::ST_RED_WAIT;
            end
            mexp_pkg::ST_RED_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_CHECK:
            begin
                priority if (sts.e_zero)
                begin
                    state_next = mexp_pkg::ST_DONE;
                end
                else if (sts.e_bit0)
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = mexp_pkg::OP_MULT;
                    state_next = mexp_pkg::ST_MUL_WAIT;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = mexp_pkg::OP_SQUARE;
                    state_next = mexp_pkg::ST_SQR_WAIT;
                end
            end
            mexp_pkg::ST_MUL_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = mexp_pkg::ST_SQR_START;
                end
            end
            mexp_pkg::ST_SQR_START:
            begin
                cmd.start  = 1'b1;
                cmd.op     = mexp_pkg::OP_SQUARE;
                state_next = mexp_pkg::ST_SQR_WAIT;
            end
            mexp_pkg::ST_SQR_WAIT:
            begin
                if (sts.mul_done)
                begin
                    state_next = mexp_pkg::ST_CHECK;
                end
            end
            mexp_pkg::ST_DONE:
            begin
                // hand the word to the output register once it is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end
        endcase
    end

    assign rsp_valid = out_valid_reg;

endmodule

/* rtl/modular_exponentiation.sv */
// Modular exponentiation block: power = base ^ exponent mod modulus.
// Channels: req carries one base word, rsp returns one power word; both use
// valid/ready and move a word on a clock edge where valid and ready are high.
// exponent (index 0) and modulus (index 1) are written through cfg_we,
// cfg_index and cfg_data while the block is idle; reset sets both to 1.
// A zero modulus acts as one; an exponent of zero gives a power of 1.
// Steps: a load, then a reduction of the base, then for each exponent bit
// up to the highest set one a check, a multiply when the bit is set and
// then a square; a final check and the hand-over to the output register
// end the run. Each reduction, multiply and square runs on the one shared
// bit-serial mulmod unit that handles one multiplier bit per cycle.
// One base is processed at a time; req.ready is high only while idle.
// The finished word sits in an output register, so a new base is taken
// while rsp is stalled; a second finished word waits until the first leaves.
// Reset (rst_n, asynchronous, active low) empties the output register and
// returns the controller to idle.
// Depends on mexp_pkg, the channel interfaces, mexp_ctrl and mexp_datapath.

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = mexp_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    mexp_base_if.sink                            req,
    mexp_power_if.source                         rsp,
    input  logic                                 cfg_we,
    input  logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [mexp_pkg::DATA_WIDTH-1:0]      cfg_data
);

    logic [mexp_pkg::DATA_WIDTH-1:0] exponent_reg;
    logic [mexp_pkg::DATA_WIDTH-1:0] modulus_reg;
    logic [OPERAND_WIDTH-1:0]        power_w;
    mexp_pkg::cmd_t                  cmd;
    mexp_pkg::sts_t                  sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exponent_reg <= mexp_pkg::DATA_WIDTH'(1);
            modulus_reg  <= mexp_pkg::DATA_WIDTH'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mexp_pkg::REG_EXPONENT:
                begin
                    exponent_reg <= cfg_data;
                end
                mexp_pkg::REG_MODULUS:
                begin
                    modulus_reg <= cfg_data;
                end
            endcase
        end
    end

    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mexp_datapath #(
        .W (OPERAND_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .base     (req.base),
        .exponent (exponent_reg),
        .modulus  (modulus_reg),
        .power    (power_w)
    );

    assign rsp.power = mexp_pkg::DATA_WIDTH'(power_w);

endmodule

/* test/tb_modular_exponentiation.sv */
// testbench for modular_exponentiation: streams base words through the block and
// checks each power word against an in-bench square-and-multiply predictor
// depends on mexp_pkg, mexp_base_if, mexp_power_if and the modular_exponentiation rtl
`timescale 1ns / 1ps

module tb_modular_exponentiation;

    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int RANDOM_KEYS = 16;
    localparam int WORDS_PER_KEY = 16;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [mexp_pkg::DATA_WIDTH-1:0]      cfg_data;

    mexp_base_if  base_ch();
    mexp_power_if power_ch();

    modular_exponentiation DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (base_ch),
        .rsp       (power_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the key registers as last written
    logic [31:0] key_exponent = 32'd1;
    logic [31:0] key_modulus  = 32'd1;

    logic [31:0] base_pending[$];
    logic [31:0] power_expected[$];
    int          mismatches = 0;
    int          cycle_count = 0;

    logic        base_fire = 1'b0;
    logic        power_fire = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    logic [31:0] stall_pattern = '1;
    int          pattern_left = 0;
    int          long_stall = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // right-to-left square and multiply, zero modulus acts as one
    function automatic logic [31:0] calc_power(input logic [31:0] b, input logic [31:0] e,
                                               input logic [31:0] m);
        logic [63:0] acc;
        logic [63:0] square;
        logic [63:0] divisor;
        logic [31:0] rest;
        divisor = (m == 32'd0) ? 64'd1 : {32'd0, m};
        acc = 64'd1;
        square = {32'd0, b};
        rest = e;
        while (rest != 32'd0)
        begin
            if (rest[0])
                acc = (acc * square) % divisor;
            square = (square * square) % divisor;
            rest = rest >> 1;
        end
        return acc[31:0];
    endfunction

    function automatic logic [31:0] pick_exponent();
        logic [31:0] mask;
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2, 3: return 32'($urandom_range(1, 255));
            4, 5:
            begin
                mask = (32'd1 << $urandom_range(1, 31)) - 32'd1;
                return $urandom & mask;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_modulus();
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return 32'd1;
            2, 3: return 32'($urandom_range(2, 255));
            4: return 32'd1 << $urandom_range(1, 31);
            5: return 32'hFFFF_FFFF - 32'($urandom_range(0, 100));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_base(input logic [31:0] m);
        case ($urandom_range(0, 11))
            0: return 32'd0;
            1: return 32'd1;
            2: return m - 32'd1;
            3: return m;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input logic [mexp_pkg::CFG_INDEX_WIDTH-1:0] index,
                             input logic [31:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == mexp_pkg::REG_EXPONENT)
            key_exponent = value;
        else
            key_modulus = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_key(input logic [31:0] e, input logic [31:0] m);
        write_reg(mexp_pkg::REG_EXPONENT, e);
        write_reg(mexp_pkg::REG_MODULUS, m);
    endtask

    // the sender holds off here until every power word is back
    task automatic wait_drained();
        while (base_pending.size() != 0 || base_ch.valid || power_expected.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // sender: bursts of words with random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            base_ch.valid <= 1'b0;
        end
        else if (!base_ch.valid || base_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                base_ch.valid <= 1'b0;
            end
            else if (base_pending.size() == 0)
            begin
                base_ch.valid <= 1'b0;
            end
            else
            begin
                base_ch.valid <= 1'b1;
                base_ch.base <= base_pending.pop_front();
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 6);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                end
            end
        end
    end

    // receiver: rotating stall pattern, now and then a stall long enough to back up a word
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            power_ch.ready <= 1'b0;
        end
        else
        begin
            if (power_fire && $urandom_range(0, 29) == 0)
                long_stall = $urandom_range(2300, 5000);
            if (long_stall > 0)
            begin
                long_stall--;
                power_ch.ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    stall_pattern = ($urandom_range(0, 2) == 0) ? '1 : $urandom;
                    pattern_left = 32;
                end
                power_ch.ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[31:1]};
                pattern_left--;
            end
        end
    end

    // monitor: predicts on each accepted base word, checks each accepted power word
    always @(posedge clk)
    begin
        base_fire <= base_ch.valid && base_ch.ready;
        power_fire <= power_ch.valid && power_ch.ready;
        if (rst_n)
        begin
            if (base_ch.valid && base_ch.ready)
                power_expected.push_back(calc_power(base_ch.base, key_exponent, key_modulus));
            if (power_ch.valid && power_ch.ready)
            begin
                if (power_expected.size() == 0)
                    report("unexpected power word", power_ch.power, 32'd0);
                else if (power_ch.power !== power_expected[0])
                    report("power", power_ch.power, power_expected.pop_front());
                else
                    void'(power_expected.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mexp_pkg::REG_EXPONENT;
        cfg_data = '0;
        base_ch.valid = 1'b0;
        base_ch.base = '0;
        power_ch.ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // key left at reset: exponent one, modulus one gives zero
        base_pending.push_back(32'h0000_0000);
        base_pending.push_back(32'h0000_0005);
        wait_drained();

        // zero exponent gives one even with modulus one
        write_key(32'd0, 32'd1);
        base_pending.push_back(32'h0000_0000);
        base_pending.push_back(32'hFFFF_FFFF);
        wait_drained();

        // all-ones exponent and modulus: longest run
        write_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        base_pending.push_back(32'h0000_0000);
        base_pending.push_back(32'h0000_0001);
        base_pending.push_back(32'hFFFF_FFFF);
        base_pending.push_back(32'hFFFF_FFFE);
        base_pending.push_back(32'h8000_0000);
        wait_drained();

        write_key(32'd65537, 32'hFFFF_FFFB);
        base_pending.push_back(32'h0000_0002);
        base_pending.push_back(32'h1234_5678);
        base_pending.push_back(32'hFFFF_FFFA);
        wait_drained();

        // zero modulus acts as one
        write_reg(mexp_pkg::REG_MODULUS, 32'd0);
        base_pending.push_back(32'h0000_0007);
        base_pending.push_back(32'h0000_0000);
        wait_drained();

        write_reg(mexp_pkg::REG_EXPONENT, 32'd0);
        base_pending.push_back(32'h0000_0009);
        wait_drained();

        write_key(32'd1, 32'h8000_0000);
        base_pending.push_back(32'hFFFF_FFFF);
        base_pending.push_back(32'h5555_5555);
        wait_drained();

        write_key(32'd3, 32'd7);
        for (int i = 0; i < 4; i++)
            base_pending.push_back(32'(i));
        wait_drained();

        for (int k = 0; k < RANDOM_KEYS; k++)
        begin
            write_key(pick_exponent(), pick_modulus());
            for (int i = 0; i < WORDS_PER_KEY; i++)
                base_pending.push_back(pick_base(key_modulus));
            wait_drained();
        end

        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* modular_exponentiation.f */
rtl/mexp_pkg.sv
rtl/mexp_base_if.sv
rtl/mexp_power_if.sv
rtl/mexp_mulmod.sv
rtl/mexp_datapath.sv
rtl/mexp_ctrl.sv
rtl/modular_exponentiation.sv
test/tb_modular_exponentiation.sv
